// ----- hdl/block_scaled_int8_dot_product_top_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef BLOCK_SCALED_INT8_DOT_PRODUCT_TOP_ASSERT_SVH
`define BLOCK_SCALED_INT8_DOT_PRODUCT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BSDP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsdp assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BSDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsdp assertion failed");

// Next-cycle implication that is also checked across reset.
`define BSDP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bsdp reset assertion failed");

`endif

// ----- hdl/bsdp_pkg.sv -----
`default_nettype none
package bsdp_pkg;

  typedef enum logic [1:0] {
    REQ_SCALE = 2'd0,
    REQ_MICRO = 2'd1,
    REQ_DOT   = 2'd2,
    REQ_FLAT  = 2'd3
  } req_t;

  localparam logic KIND_DOT  = 1'b0;
  localparam logic KIND_FLAT = 1'b1;

  localparam logic [7:0]  SCALE_RESET = 8'd127;
  localparam logic [31:0] FP_QNAN     = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET    = 32'h0040_0000;
  localparam logic [7:0]  FP_EXP_MAX  = 8'hFF;

  // Front end to converter: data is the int32 sum, or the flattened word.
  typedef struct packed {
    logic        kind;
    logic [31:0] data;
    logic [8:0]  sexp;
    logic [31:0] c;
  } front_t;

  // Converter to adder: data is the scaled FP32 dot, or the flattened word.
  typedef struct packed {
    logic        kind;
    logic [31:0] data;
    logic [31:0] c;
  } cvt_t;

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bsdp_in_if.sv -----
`default_nettype none
interface bsdp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  warp;
  logic [2:0]  thread;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [1:0]  mexp_a_bits;
  logic [1:0]  mexp_b_bits;
  logic        tile_b;
  logic [31:0] accum_c;
  logic        first;
  logic        last;

  modport source (
    output valid, req_type, warp, thread, word_a, word_b, mexp_a_bits, mexp_b_bits,
           tile_b, accum_c, first, last,
    input  ready
  );
  modport sink (
    input  valid, req_type, warp, thread, word_a, word_b, mexp_a_bits, mexp_b_bits,
           tile_b, accum_c, first, last,
    output ready
  );
endinterface
`default_nettype wire

// ----- hdl/bsdp_out_if.sv -----
`default_nettype none
interface bsdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        result_kind;

  modport source (output valid, result, result_kind, input ready);
  modport sink (input valid, result, result_kind, output ready);
endinterface
`default_nettype wire

// ----- hdl/bsdp_front.sv -----
`default_nettype none
module bsdp_front
  import bsdp_pkg::*;
#(
  parameter int WARPS   = 4,
  parameter int THREADS = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  bsdp_in_if.sink in_ch,
  output logic   o_valid,
  input  logic   o_ready,
  output front_t o_data
);

  localparam int NE = WARPS * THREADS;
  localparam int WB = (WARPS > 1) ? $clog2(WARPS) : 1;
  localparam int IB = (NE > 1) ? $clog2(NE) : 1;

  typedef struct packed {
    req_t        req;
    logic [1:0]  warp;
    logic [2:0]  thread;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [1:0]  ma;
    logic [1:0]  mb;
    logic        tb;
    logic [31:0] c;
    logic        first;
    logic        last;
  } item_t;

  function automatic logic [WB-1:0] warp_mod(input logic [1:0] v);
    int r;
    r = int'(v);
    for (int i = 0; i < 4; i++) begin
      if (r >= WARPS) r = r - WARPS;
    end
    return WB'(r);
  endfunction

  function automatic int thread_mod(input logic [2:0] v);
    int r;
    r = int'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= THREADS) r = r - THREADS;
    end
    return r;
  endfunction

  // Doubles a byte and saturates to int8 when its micro-exponent bit is set.
  function automatic logic [7:0] flat8(input logic [7:0] raw, input logic dbl);
    logic [8:0] d;
    d = {raw, 1'b0};
    if (!dbl) return raw;
    if (d[8] != d[7]) return d[8] ? 8'h80 : 8'h7F;
    return d[7:0];
  endfunction

  logic [3:0]  micro_mem [NE];
  logic [15:0] scale_mem [WARPS];

  logic          clr_busy_r;
  logic [IB-1:0] clr_cnt_r;

  logic          s0_v_r, s1_v_r;
  item_t         s0_r, s1_r;
  logic [3:0]    micro_rd_r;
  logic [15:0]   scale_rd_r;
  logic [31:0]   dot_sum_r;

  logic          rdy0, rdy1, rdy2;
  logic [WB-1:0] w0;
  logic [IB-1:0] idx0;

  assign rdy2 = !o_valid || o_ready;
  assign rdy1 = !s1_v_r || rdy2;
  assign rdy0 = !s0_v_r || rdy1;
  assign in_ch.ready = rdy0 && !clr_busy_r;

  assign w0   = warp_mod(s0_r.warp);
  assign idx0 = IB'(int'(w0) * THREADS + thread_mod(s0_r.thread));

  // Clearing pass over the micro-exponent and scale stores after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == IB'(NE - 1)) clr_busy_r <= 1'b0;
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      micro_mem[clr_cnt_r] <= '0;
      if (int'(clr_cnt_r) < WARPS) scale_mem[clr_cnt_r[WB-1:0]] <= {SCALE_RESET, SCALE_RESET};
    end else if (s0_v_r && rdy1) begin
      if (s0_r.req == REQ_SCALE) scale_mem[w0] <= s0_r.wa[15:0];
      if (s0_r.req == REQ_MICRO) micro_mem[idx0] <= {s0_r.mb, s0_r.ma};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (rdy0) begin
      s0_v_r <= in_ch.valid && !clr_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s0_r.req    <= req_t'(in_ch.req_type);
      s0_r.warp   <= in_ch.warp;
      s0_r.thread <= in_ch.thread;
      s0_r.wa     <= in_ch.word_a;
      s0_r.wb     <= in_ch.word_b;
      s0_r.ma     <= in_ch.mexp_a_bits;
      s0_r.mb     <= in_ch.mexp_b_bits;
      s0_r.tb     <= in_ch.tile_b;
      s0_r.c      <= in_ch.accum_c;
      s0_r.first  <= in_ch.first;
      s0_r.last   <= in_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r       <= s0_r;
      micro_rd_r <= micro_mem[idx0];
      scale_rd_r <= scale_mem[w0];
    end
  end

  // Stage 1: flatten, multiply and accumulate.
  logic [7:0]  fa [4];
  logic [7:0]  fb [4];
  logic [7:0]  ff [4];
  logic [1:0]  sel_flat;
  logic [31:0] psum, sum_new, flat_word;
  logic        s1_dot, s1_emit;

  always_comb begin
    sel_flat = s1_r.tb ? micro_rd_r[3:2] : micro_rd_r[1:0];
    psum = '0;
    for (int b = 0; b < 4; b++) begin
      fa[b] = flat8(s1_r.wa[8*b +: 8], micro_rd_r[b / 2]);
      fb[b] = flat8(s1_r.wb[8*b +: 8], micro_rd_r[2 + b / 2]);
      ff[b] = flat8(s1_r.wa[8*b +: 8], sel_flat[b / 2]);
      psum  = psum + 32'(signed'(16'(signed'(fa[b]) * signed'(fb[b]))));
    end
    sum_new   = (s1_r.first ? 32'd0 : dot_sum_r) + psum;
    flat_word = {ff[3], ff[2], ff[1], ff[0]};
    s1_dot    = s1_r.req == REQ_DOT;
    s1_emit   = (s1_dot && s1_r.last) || (s1_r.req == REQ_FLAT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_sum_r <= '0;
      o_valid   <= 1'b0;
    end else if (rdy2) begin
      o_valid <= s1_v_r && s1_emit;
      if (s1_v_r && s1_dot) dot_sum_r <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      o_data.kind <= s1_dot ? KIND_DOT : KIND_FLAT;
      o_data.data <= s1_dot ? sum_new : flat_word;
      o_data.sexp <= 9'(scale_rd_r[7:0]) + 9'(scale_rd_r[15:8]);
      o_data.c    <= s1_r.c;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/bsdp_cvt.sv -----
`default_nettype none
module bsdp_cvt
  import bsdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   i_valid,
  output logic   i_ready,
  input  front_t i_data,
  output logic   o_valid,
  input  logic   o_ready,
  output cvt_t   o_data
);

  typedef struct packed {
    logic        kind;
    logic [31:0] data;
    logic        sign;
    logic [5:0]  lz;
    logic [8:0]  sexp;
    logic [31:0] c;
  } sa_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic        sign;
    logic        zero;
    logic [23:0] m;
    logic [5:0]  e;
    logic [8:0]  sexp;
    logic [31:0] c;
  } sb_t;

  logic sa_v_r, sb_v_r;
  sa_t  sa_r;
  sb_t  sb_r;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c   = !o_valid || o_ready;
  assign rdy_b   = !sb_v_r || rdy_c;
  assign rdy_a   = !sa_v_r || rdy_b;
  assign i_ready = rdy_a;

  // Stage A: magnitude and leading-zero count.
  logic [31:0] mag;
  assign mag = i_data.data[31] ? (32'd0 - i_data.data) : i_data.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
      sb_v_r <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (rdy_a) sa_v_r <= i_valid;
      if (rdy_b) sb_v_r <= sa_v_r;
      if (rdy_c) o_valid <= sb_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      sa_r.kind <= i_data.kind;
      sa_r.data <= (i_data.kind == KIND_FLAT) ? i_data.data : mag;
      sa_r.sign <= i_data.data[31];
      sa_r.lz   <= lzc32(mag);
      sa_r.sexp <= i_data.sexp;
      sa_r.c    <= i_data.c;
    end
  end

  // Stage B: normalize and round the integer to a 24-bit significand.
  logic [31:0] norm;
  logic [24:0] m25;
  logic        up_b;

  always_comb begin
    norm = sa_r.data << sa_r.lz;
    up_b = norm[7] && ((|norm[6:0]) || norm[8]);
    m25  = {1'b0, norm[31:8]} + 25'(up_b);
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      sb_r.kind <= sa_r.kind;
      sb_r.word <= sa_r.data;
      sb_r.sign <= sa_r.sign;
      sb_r.zero <= sa_r.data == 32'd0;
      sb_r.m    <= m25[24] ? 24'h80_0000 : m25[23:0];
      sb_r.e    <= m25[24] ? (6'd32 - sa_r.lz) : (6'd31 - sa_r.lz);
      sb_r.sexp <= sa_r.sexp;
      sb_r.c    <= sa_r.c;
    end
  end

  // Stage C: apply the block scale with overflow and gradual underflow.
  logic signed [10:0] bexp, sh;
  logic [49:0] ext;
  logic [23:0] q, qr;
  logic        up_c;
  logic [31:0] fs;

  always_comb begin
    bexp = $signed({5'b0, sb_r.e}) + $signed({2'b0, sb_r.sexp}) - 11'sd127;
    sh   = 11'sd1 - bexp;
    ext  = {sb_r.m, 26'b0} >> sh[4:0];
    q    = ext[49:26];
    up_c = ext[25] && ((|ext[24:0]) || q[0]);
    qr   = q + 24'(up_c);
    if (sb_r.zero) begin
      fs = 32'd0;
    end else if (bexp >= 11'sd255) begin
      fs = {sb_r.sign, FP_EXP_MAX, 23'b0};
    end else if (bexp >= 11'sd1) begin
      fs = {sb_r.sign, bexp[7:0], sb_r.m[22:0]};
    end else if (sh > 11'sd25) begin
      fs = {sb_r.sign, 31'b0};
    end else begin
      fs = {sb_r.sign, 7'b0, qr};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      o_data.kind <= sb_r.kind;
      o_data.data <= (sb_r.kind == KIND_FLAT) ? sb_r.word : fs;
      o_data.c    <= sb_r.c;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/bsdp_fadd.sv -----
`default_nettype none
module bsdp_fadd
  import bsdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        i_valid,
  output logic        i_ready,
  input  cvt_t        i_data,
  bsdp_out_if.source  out_ch
);

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic        sub;
    logic [8:0]  e;
    logic [26:0] big;
    logic [26:0] lesser;
  } sa_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic        sub;
    logic [8:0]  e;
    logic [27:0] sum;
    logic [5:0]  lz;
  } sb_t;

  logic sa_v_r, sb_v_r;
  sa_t  sa_r;
  sb_t  sb_r;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c   = !out_ch.valid || out_ch.ready;
  assign rdy_b   = !sb_v_r || rdy_c;
  assign rdy_a   = !sa_v_r || rdy_b;
  assign i_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
      sb_v_r <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (rdy_a) sa_v_r <= i_valid;
      if (rdy_b) sb_v_r <= sa_v_r;
      if (rdy_c) out_ch.valid <= sb_v_r;
    end
  end

  // Stage A: order operands by magnitude, align the smaller one.
  logic [31:0] x, y, bg, sm;
  logic [7:0]  eb, es, d;
  logic [23:0] mb, ms;
  logic [26:0] sfull, small_al, smask;
  logic        x_inf, y_inf, y_nan;
  logic        special;
  logic [31:0] spec_val;

  always_comb begin
    x = i_data.data;
    y = i_data.c;
    if (x[30:0] >= y[30:0]) begin
      bg = x;
      sm = y;
    end else begin
      bg = y;
      sm = x;
    end
    eb = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    mb = {bg[30:23] != 8'd0, bg[22:0]};
    ms = {sm[30:23] != 8'd0, sm[22:0]};
    d  = eb - es;
    sfull = {ms, 3'b0};
    smask = (27'd1 << d[4:0]) - 27'd1;
    if (d >= 8'd27) begin
      small_al = {26'b0, |ms};
    end else begin
      small_al = sfull >> d[4:0];
      small_al[0] = small_al[0] | (|(sfull & smask));
    end
    x_inf = (x[30:23] == FP_EXP_MAX) && (x[22:0] == 23'd0);
    y_inf = (y[30:23] == FP_EXP_MAX) && (y[22:0] == 23'd0);
    y_nan = (y[30:23] == FP_EXP_MAX) && (y[22:0] != 23'd0);
    special  = 1'b1;
    spec_val = x;
    if (y_nan) begin
      spec_val = y | FP_QUIET;
    end else if (x_inf) begin
      spec_val = (y_inf && (x[31] != y[31])) ? FP_QNAN : x;
    end else if (y_inf) begin
      spec_val = y;
    end else begin
      special = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      sa_r.kind     <= i_data.kind;
      sa_r.word     <= i_data.data;
      sa_r.special  <= special;
      sa_r.spec_val <= spec_val;
      sa_r.sign     <= bg[31];
      sa_r.sub      <= bg[31] != sm[31];
      sa_r.e        <= {1'b0, eb};
      sa_r.big      <= {mb, 3'b0};
      sa_r.lesser   <= small_al;
    end
  end

  // Stage B: add or subtract the significands, count leading zeros.
  logic [27:0] sum_b;
  assign sum_b = sa_r.sub ? ({1'b0, sa_r.big} - {1'b0, sa_r.lesser})
                          : ({1'b0, sa_r.big} + {1'b0, sa_r.lesser});

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      sb_r.kind     <= sa_r.kind;
      sb_r.word     <= sa_r.word;
      sb_r.special  <= sa_r.special;
      sb_r.spec_val <= sa_r.spec_val;
      sb_r.sign     <= sa_r.sign;
      sb_r.sub      <= sa_r.sub;
      sb_r.e        <= sa_r.e;
      sb_r.sum      <= sum_b;
      sb_r.lz       <= lzc32({sum_b[26:0], 5'b0});
    end
  end

  // Stage C: normalize, round to nearest even, pack.
  logic [8:0]  shamt, ex;
  logic [26:0] m27;
  logic [24:0] mr;
  logic [23:0] mant;
  logic        up_c;
  logic        rsign;
  logic [31:0] fsum;

  always_comb begin
    shamt = 9'd0;
    if (sb_r.sum[27]) begin
      m27 = {sb_r.sum[27:2], sb_r.sum[1] | sb_r.sum[0]};
      ex  = sb_r.e + 9'd1;
    end else begin
      // The shift stops at the minimum exponent, leaving a subnormal.
      shamt = ({3'b0, sb_r.lz} < sb_r.e) ? {3'b0, sb_r.lz} : (sb_r.e - 9'd1);
      m27   = sb_r.sum[26:0] << shamt;
      ex    = sb_r.e - shamt;
    end
    up_c = m27[2] && (m27[1] || m27[0] || m27[3]);
    mr   = {1'b0, m27[26:3]} + 25'(up_c);
    if (mr[24]) begin
      mant = mr[24:1];
      ex   = ex + 9'd1;
    end else begin
      mant = mr[23:0];
    end
    rsign = sb_r.sign;
    if (sb_r.sum == 28'd0) rsign = sb_r.sub ? 1'b0 : sb_r.sign;
    if (ex >= 9'd255) begin
      fsum = {rsign, FP_EXP_MAX, 23'b0};
    end else begin
      fsum = {rsign, mant[23] ? ex[7:0] : 8'd0, mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      out_ch.result_kind <= sb_r.kind;
      if (sb_r.kind == KIND_FLAT) begin
        out_ch.result <= sb_r.word;
      end else begin
        out_ch.result <= sb_r.special ? sb_r.spec_val : fsum;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/block_scaled_int8_dot_product_top.sv -----
`default_nettype none
// Block-scaled int8 dot product. One item is taken per cycle on in_ch unless a stall on
// out_ch holds the pipeline; each dot-product result or flattened word leaves on out_ch
// after passing the front-end, converter and adder stages. Load items and dot steps
// that are not last produce nothing. After reset the block clears its micro-exponent and
// scale stores, one entry per cycle, and holds in_ch.ready low until that is done. The
// running int32 sum is updated in the second stage, so consecutive dot steps follow each
// other without gaps.
module block_scaled_int8_dot_product_top
  import bsdp_pkg::*;
#(
  parameter int WARPS   = 4,
  parameter int THREADS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  bsdp_in_if.sink    in_ch,
  bsdp_out_if.source out_ch
);

  logic   f_valid, f_ready;
  front_t f_data;
  logic   c_valid, c_ready;
  cvt_t   c_data;

  bsdp_front #(
    .WARPS   (WARPS),
    .THREADS (THREADS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .o_valid (f_valid),
    .o_ready (f_ready),
    .o_data  (f_data)
  );

  bsdp_cvt u_cvt (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (f_valid),
    .i_ready (f_ready),
    .i_data  (f_data),
    .o_valid (c_valid),
    .o_ready (c_ready),
    .o_data  (c_data)
  );

  bsdp_fadd u_fadd (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (c_valid),
    .i_ready (c_ready),
    .i_data  (c_data),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- hdl/bsdp_checker.sv -----
`default_nettype none
`include "block_scaled_int8_dot_product_top_assert.svh"
module bsdp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_result,
  input wire logic        out_result_kind
);

  // A result that is not taken stays put.
  `BSDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_result) && $stable(out_result_kind))

  // The store clearing pass keeps the input closed right after reset.
  `BSDP_ASSERT_RST(a_clear_closes_input, !rst_n, !in_ready)

  // No result can be pending in the cycle after reset is released.
  `BSDP_ASSERT_IMPL(a_no_out_after_reset, !$past(rst_n), !out_valid)

  // A result on offer always carries a fully known payload.
  `BSDP_ASSERT_IMPL(a_out_known, out_valid,
    !$isunknown({out_result, out_result_kind}))

endmodule

bind block_scaled_int8_dot_product_top bsdp_checker u_bsdp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result      (out_ch.result),
  .out_result_kind (out_ch.result_kind)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import bsdp_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    req_t        req;
    logic [1:0]  warp;
    logic [2:0]  thread;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [1:0]  ma;
    logic [1:0]  mb;
    logic        tb;
    logic [31:0] c;
    logic        first;
    logic        last;
  } item_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   cycles;
  int   max_gap;
  int   hold_cycles;
  int   dots_seen;
  int   flats_seen;

  bsdp_in_if  in_ch ();
  bsdp_out_if out_ch ();

  block_scaled_int8_dot_product_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    errors++;
  endtask

  // Rounds sign * mag * 2^e to FP32, nearest even, with gradual underflow.
  function automatic logic [31:0] fp_round_pack(input logic sign, input logic [319:0] mag,
                                                input int e);
    int p, x, q, sh;
    logic [319:0] mant, rem, half;
    logic [7:0] bexp;
    if (mag == '0) return {sign, 31'b0};
    p = 0;
    for (int i = 319; i >= 0; i--) begin
      if (mag[i] && p == 0) p = i;
    end
    x = p + e;
    if (x > 128) return {sign, 8'hFF, 23'b0};
    q = x - 23;
    if (q < -149) q = -149;
    sh = q - e;
    if (sh <= 0) begin
      mant = mag << (-sh);
    end else begin
      mant = mag >> sh;
      rem  = mag & ((320'b1 << sh) - 1);
      half = 320'b1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 1;
    end
    if (mant[24]) begin
      mant = mant >> 1;
      q++;
    end
    if (mant[23] && q + 150 >= 255) return {sign, 8'hFF, 23'b0};
    bexp = mant[23] ? 8'(q + 150) : 8'd0;
    return {sign, bexp, mant[22:0]};
  endfunction

  // Splits a finite FP32 into an integer significand and its exponent.
  function automatic void fp_split(input logic [31:0] f, output logic [319:0] m, output int e);
    if (f[30:23] == 8'd0) begin
      m = 320'(f[22:0]);
      e = -149;
    end else begin
      m = 320'({1'b1, f[22:0]});
      e = int'(f[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] c);
    logic [319:0] ma, mc, mag;
    int ea, ec;
    logic sign;
    if (c[30:23] == 8'hFF && c[22:0] != 0) return c | FP_QUIET;
    if (c[30:23] == 8'hFF) begin
      if (a[30:23] == 8'hFF && a[31] != c[31]) return FP_QNAN;
      return c;
    end
    if (a[30:23] == 8'hFF) return a;
    fp_split(a, ma, ea);
    fp_split(c, mc, ec);
    ma = ma << (ea + 149);
    mc = mc << (ec + 149);
    if (a[31] == c[31]) begin
      mag = ma + mc;
      sign = a[31];
    end else if (ma >= mc) begin
      mag = ma - mc;
      sign = a[31];
    end else begin
      mag = mc - ma;
      sign = c[31];
    end
    if (mag == '0) sign = a[31] & c[31];
    return fp_round_pack(sign, mag, -149);
  endfunction

  function automatic logic signed [7:0] flat_byte(input logic [7:0] raw, input logic dbl);
    int v;
    v = int'($signed(raw));
    if (dbl) begin
      v = v * 2;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
    end
    return 8'(v);
  endfunction

  class dot_scoreboard;
    logic [7:0]  scale_a[4];
    logic [7:0]  scale_b[4];
    logic [1:0]  micro_a[32];
    logic [1:0]  micro_b[32];
    logic [31:0] acc;
    logic [32:0] expected_q[$];

    function new();
      foreach (scale_a[i]) begin
        scale_a[i] = SCALE_RESET;
        scale_b[i] = SCALE_RESET;
      end
      foreach (micro_a[i]) begin
        micro_a[i] = 2'b0;
        micro_b[i] = 2'b0;
      end
      acc = '0;
    endfunction

    function void note_input(item_t it);
      int idx, ex;
      logic [1:0] mxa, mxb, mx;
      logic [31:0] w, dot_fp, scaled, mag;
      logic [319:0] m;
      logic signed [7:0] x, y;
      idx = int'(it.warp) * 8 + int'(it.thread);
      case (it.req)
        REQ_SCALE: begin
          scale_a[it.warp] = it.wa[7:0];
          scale_b[it.warp] = it.wa[15:8];
        end
        REQ_MICRO: begin
          micro_a[idx] = it.ma;
          micro_b[idx] = it.mb;
        end
        REQ_DOT: begin
          mxa = micro_a[idx];
          mxb = micro_b[idx];
          if (it.first) acc = '0;
          for (int b = 0; b < 4; b++) begin
            x = flat_byte(it.wa[8*b +: 8], mxa[b/2]);
            y = flat_byte(it.wb[8*b +: 8], mxb[b/2]);
            acc = acc + 32'(int'(x) * int'(y));
          end
          if (it.last) begin
            mag = acc[31] ? -acc : acc;
            dot_fp = fp_round_pack(acc[31], 320'(mag), 0);
            fp_split(dot_fp, m, ex);
            scaled = fp_round_pack(dot_fp[31], m,
                                   ex + int'(scale_a[it.warp]) + int'(scale_b[it.warp]) - 254);
            expected_q.push_back({KIND_DOT, fp_add(scaled, it.c)});
          end
        end
        default: begin
          mx = it.tb ? micro_b[idx] : micro_a[idx];
          for (int b = 0; b < 4; b++) w[8*b +: 8] = flat_byte(it.wa[8*b +: 8], mx[b/2]);
          expected_q.push_back({KIND_FLAT, w});
        end
      endcase
    endfunction

    task check_result(input logic [31:0] r, input logic k);
      logic [32:0] want;
      if (expected_q.size() == 0) begin
        report("unexpected transfer", r, 32'(k));
        return;
      end
      want = expected_q.pop_front();
      if (k != want[32]) report("result_kind", 32'(k), 32'(want[32]));
      if (r != want[31:0]) report("result", r, want[31:0]);
      if (k == KIND_DOT) dots_seen++;
      else flats_seen++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  dot_scoreboard sb;

  task automatic send(input item_t it);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.req_type    = it.req;
    in_ch.warp        = it.warp;
    in_ch.thread      = it.thread;
    in_ch.word_a      = it.wa;
    in_ch.word_b      = it.wb;
    in_ch.mexp_a_bits = it.ma;
    in_ch.mexp_b_bits = it.mb;
    in_ch.tile_b      = it.tb;
    in_ch.accum_c     = it.c;
    in_ch.first       = it.first;
    in_ch.last        = it.last;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  always begin
    int wait_cycles;
    @(negedge clk);
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      repeat (hold_cycles) @(negedge clk);
      hold_cycles = 0;
    end
    wait_cycles = $urandom_range(0, max_gap);
    if (wait_cycles > 0) begin
      out_ch.ready = 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    out_ch.ready = 1'b1;
    do @(posedge clk); while (!out_ch.valid);
    sb.check_result(out_ch.result, out_ch.result_kind);
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'(2'($urandom) - 2);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  function automatic logic [31:0] rand_c();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 31'b0};
      1: return {1'($urandom), 8'hFF, 23'b0};
      2: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      3: return {1'($urandom), 8'h00, 23'($urandom)};
      4: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(110, 160)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom);
      default: return 8'($urandom_range(100, 154));
    endcase
  endfunction

  function automatic item_t make_item(input req_t req);
    item_t it;
    it.req    = req;
    it.warp   = 2'($urandom);
    it.thread = 3'($urandom);
    it.wa     = rand_word();
    it.wb     = rand_word();
    it.ma     = 2'($urandom);
    it.mb     = 2'($urandom);
    it.tb     = 1'($urandom);
    it.c      = rand_c();
    it.first  = 1'($urandom);
    it.last   = 1'($urandom);
    if (req == REQ_SCALE) it.wa[15:0] = {rand_scale(), rand_scale()};
    return it;
  endfunction

  initial begin
    item_t it;
    int n, steps;
    errors = 0;
    cycles = 0;
    max_gap = 0;
    hold_cycles = 0;
    dots_seen = 0;
    flats_seen = 0;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_SCALE;
    in_ch.warp = '0;
    in_ch.thread = '0;
    in_ch.word_a = '0;
    in_ch.word_b = '0;
    in_ch.mexp_a_bits = '0;
    in_ch.mexp_b_bits = '0;
    in_ch.tile_b = 1'b0;
    in_ch.accum_c = '0;
    in_ch.first = 1'b0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset state, extreme bytes and scales, micro-exponents, flatten.
    it = make_item(REQ_DOT);
    it.wa = 32'h8080_8080; it.wb = 32'h8080_8080; it.first = 1; it.last = 1; it.c = 0;
    send(it);
    it = make_item(REQ_FLAT); it.wa = 32'h807F_C040; it.tb = 0; send(it);
    it = make_item(REQ_MICRO); it.warp = 3; it.thread = 7; it.ma = 3; it.mb = 1; send(it);
    it = make_item(REQ_FLAT); it.warp = 3; it.thread = 7; it.wa = 32'h807F_C040; it.tb = 0;
    send(it);
    it.tb = 1; send(it);
    it = make_item(REQ_DOT); it.warp = 3; it.thread = 7;
    it.wa = 32'h7F80_4001; it.wb = 32'h807F_C0FF; it.first = 1; it.last = 0; send(it);
    it.first = 0; it.last = 1; it.c = 32'h3F80_0000; send(it);
    it = make_item(REQ_SCALE); it.warp = 1; it.wa = 32'h0000_FFFF; send(it);
    it = make_item(REQ_DOT); it.warp = 1; it.wa = 32'h7F7F_7F7F; it.wb = 32'h7F7F_7F7F;
    it.first = 1; it.last = 1; it.c = 32'h3F80_0000; send(it);
    it.c = 32'hFF80_0000; send(it);
    it = make_item(REQ_SCALE); it.warp = 2; it.wa = 32'h0000_0000; send(it);
    it = make_item(REQ_DOT); it.warp = 2; it.wa = 32'h0101_0101; it.wb = 32'h0000_0001;
    it.first = 1; it.last = 1; it.c = 32'h0000_0001; send(it);
    it.c = 32'h7FC1_2345; send(it);
    it.wb = 32'h0000_00FF; it.c = 32'h0000_0000; send(it);
    it = make_item(REQ_SCALE); it.warp = 0; it.wa = 32'h0000_7F80; send(it);
    it = make_item(REQ_DOT); it.warp = 0; it.thread = 0; it.first = 1; it.last = 1;
    it.wa = 32'h0000_0003; it.wb = 32'h0000_0005; it.c = 32'hC170_0000; send(it);

    // Long accumulation with first only on its opening step, carrying the sum across many steps.
    it = make_item(REQ_MICRO); it.warp = 0; it.thread = 1; it.ma = 0; it.mb = 0; send(it);
    it = make_item(REQ_DOT); it.warp = 0; it.thread = 1;
    it.wa = 32'h8080_8080; it.wb = 32'h8080_8080; it.first = 1; it.last = 0;
    for (int i = 0; i < 40; i++) begin
      send(it);
      it.first = 0;
    end
    it.last = 1; it.c = 0; send(it);

    // Receiver stalls for a long stretch while flatten items keep arriving.
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send(make_item(REQ_FLAT));

    // Random part: mostly whole dot sequences, mixed with loads and flattens.
    n = 0;
    while (n < 650) begin
      if ((n / 60) % 2 == 0) max_gap = 11;
      else max_gap = 0;
      case ($urandom_range(0, 9))
        0: send(make_item(REQ_SCALE));
        1: send(make_item(REQ_MICRO));
        2: send(make_item(REQ_FLAT));
        3: send(make_item(REQ_DOT));
        default: begin
          steps = $urandom_range(1, 5);
          it = make_item(REQ_DOT);
          for (int s = 0; s < steps; s++) begin
            it.wa = rand_word();
            it.wb = rand_word();
            it.first = (s == 0);
            it.last = (s == steps - 1);
            send(it);
            n++;
          end
        end
      endcase
      n++;
    end
    in_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Covered scale and micro-exponent loads, long dot sums, FP specials");
    $display("and flatten words: %0d dot results and %0d flattened words checked.",
             dots_seen, flats_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
